/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the Euler tour block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DET_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define DET_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define DET_ASSERT(lbl, clk, rst, prop)
`define DET_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* sv/det_pkg.sv */
// Types, constants and helpers for the depth-first Euler tour block
`timescale 1ns / 1ps
package det_pkg;

  localparam int NODES  = 32;
  localparam int EDGES  = 64;

  localparam int NODE_W = 5;
  localparam int TICK_W = 6;
  localparam int STAT_W = 3;
  localparam int OP_W   = 2;
  localparam int EIDX_W = $clog2(EDGES);
  localparam int LINK_W = EIDX_W + 1;
  localparam int SIDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SP_W   = $clog2(NODES + 1);
  localparam int CNT_W  = $clog2(EDGES + 1);

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(EDGES);

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_ENTER   = 3'd0;
  localparam logic [STAT_W-1:0] ST_LEAVE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_STORED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic              wr_new;
    logic              wr_link;
    logic [EIDX_W-1:0] addr;
    logic [NODE_W-1:0] target;
    logic [LINK_W-1:0] link;
  } edge_req_t;

  typedef struct packed {
    logic              clear;
    logic              wr;
    logic [SIDX_W-1:0] addr;
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
  } list_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [LINK_W-1:0] cur;
  } stack_ent_t;

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return (NODE_W + 1)'(n) < (NODE_W + 1)'(NODES);
  endfunction

  function automatic logic link_null(input logic [LINK_W-1:0] l);
    return l >= NULL_LINK;
  endfunction

endpackage

/* sv/det_edge_mem.sv */
// Edge store: target node and next link of each adjacency entry
`timescale 1ns / 1ps
module det_edge_mem import det_pkg::*; (
  input  logic              clk,
  input  edge_req_t         req,
  output logic [NODE_W-1:0] rd_target,
  output logic [LINK_W-1:0] rd_link
);

  logic [NODE_W-1:0] target_mem [EDGES];
  logic [LINK_W-1:0] link_mem   [EDGES];

  always_ff @(posedge clk) begin
    if (req.wr_new) begin
      target_mem[req.addr] <= req.target;
      link_mem[req.addr]   <= req.link;
    end
    if (req.wr_link) begin
      link_mem[req.addr] <= req.link;
    end
    rd_target <= target_mem[req.addr];
    rd_link   <= link_mem[req.addr];
  end

endmodule

/* sv/det_list_mem.sv */
// Per-node list head and tail store; entries not yet written read as null
`timescale 1ns / 1ps
module det_list_mem import det_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  list_req_t         req,
  output logic [LINK_W-1:0] rd_head,
  output logic [LINK_W-1:0] rd_tail
);

  logic [LINK_W-1:0] head_mem [NODES];
  logic [LINK_W-1:0] tail_mem [NODES];
  logic [NODES-1:0]  valid;
  logic [LINK_W-1:0] head_raw;
  logic [LINK_W-1:0] tail_raw;
  logic              rd_valid;

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr) begin
      valid[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      head_mem[req.addr] <= req.head;
      tail_mem[req.addr] <= req.tail;
    end
    head_raw <= head_mem[req.addr];
    tail_raw <= tail_mem[req.addr];
    rd_valid <= valid[req.addr];
  end

  assign rd_head = rd_valid ? head_raw : NULL_LINK;
  assign rd_tail = rd_valid ? tail_raw : NULL_LINK;

endmodule

/* sv/det_stack_mem.sv */
// Walk stack store: node and list cursor of every frame below the top
`timescale 1ns / 1ps
module det_stack_mem import det_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [SIDX_W-1:0] waddr,
  input  stack_ent_t        wdata,
  input  logic [SIDX_W-1:0] raddr,
  output stack_ent_t        rdata
);

  stack_ent_t mem [NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/dfs_euler_tour_top.sv */
// Top level: command decode and depth-first walk sequencer over the stores
// Add: S_ADD_B writes the entry, S_ADD_C chains the old tail, then stored;
// dropped add and clear: result in the cycle after accept. Run: start node
// enter in the cycle after accept, then S_HEAD, S_STEP, S_EDGE and S_POP on
// one-port stores; busy stays high until the final leave result is shown.
// Reset clears the lists, edge count and tick at once; no clearing pass.
// Results last one cycle each on strobe; the receiver cannot stall them.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dfs_euler_tour_top import det_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   op,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  output logic              strobe,
  output logic [STAT_W-1:0] status,
  output logic [NODE_W-1:0] node,
  output logic [TICK_W-1:0] stamp,
  output logic              last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD_B = 3'd1;
  localparam logic [2:0] S_ADD_C = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;
  localparam logic [2:0] S_EDGE  = 3'd6;

  logic [2:0]        state;
  logic [CNT_W-1:0]  edges_used;
  logic [TICK_W-1:0] tick;
  logic [SP_W-1:0]   sp;
  logic [NODE_W-1:0] top_node;
  logic [LINK_W-1:0] top_cur;
  logic [NODES-1:0]  seen;
  logic [NODE_W-1:0] add_from;
  logic [NODE_W-1:0] add_to;
  logic [LINK_W-1:0] add_tail;
  logic [EIDX_W-1:0] add_edge;

  edge_req_t         edge_req;
  list_req_t         list_req;
  logic [NODE_W-1:0] edge_rd_target;
  logic [LINK_W-1:0] edge_rd_link;
  logic [LINK_W-1:0] list_rd_head;
  logic [LINK_W-1:0] list_rd_tail;
  logic              stk_we;
  logic [SIDX_W-1:0] stk_waddr;
  logic [SIDX_W-1:0] stk_raddr;
  stack_ent_t        stk_wdata;
  stack_ent_t        stk_rdata;

  logic              accept;
  logic              edges_full;
  logic              add_drop;
  logic              emit;
  logic [EIDX_W-1:0] new_edge;
  logic [SP_W-1:0]   sp_m1;
  logic [SP_W-1:0]   sp_m2;
  logic [SIDX_W-1:0] x_idx;
  logic              take_x;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign edges_full = (edges_used >= CNT_W'(EDGES));
  assign add_drop   = !node_ok(from_node) || !node_ok(to_node) || edges_full;
  assign new_edge   = edges_used[EIDX_W-1:0];
  assign sp_m1      = sp - SP_W'(1);
  assign sp_m2      = sp - SP_W'(2);
  assign x_idx      = edge_rd_target[SIDX_W-1:0];
  assign take_x     = node_ok(edge_rd_target) && !seen[x_idx] && (sp < SP_W'(NODES));

  // a result goes out on the edge after any of these
  assign emit = (accept && (((op == OP_ADD) && add_drop) ||
                            ((op == OP_RUN) && node_ok(from_node)) ||
                            (op == OP_CLEAR)))
             || (state == S_ADD_C)
             || ((state == S_STEP) && link_null(top_cur))
             || ((state == S_EDGE) && take_x);

  // store requests
  always_comb begin
    edge_req        = '0;
    edge_req.addr   = top_cur[EIDX_W-1:0];
    list_req        = '0;
    list_req.addr   = from_node[SIDX_W-1:0];
    stk_we          = 1'b0;
    stk_waddr       = sp_m1[SIDX_W-1:0];
    stk_raddr       = sp_m2[SIDX_W-1:0];
    stk_wdata.node  = top_node;
    stk_wdata.cur   = edge_rd_link;
    case (state)
      S_IDLE: begin
        list_req.clear = accept && (op == OP_CLEAR);
      end
      S_ADD_B: begin
        edge_req.wr_new = 1'b1;
        edge_req.addr   = new_edge;
        edge_req.target = add_to;
        edge_req.link   = NULL_LINK;
        list_req.wr     = 1'b1;
        list_req.addr   = add_from[SIDX_W-1:0];
        list_req.head   = link_null(list_rd_tail) ? LINK_W'(new_edge) : list_rd_head;
        list_req.tail   = LINK_W'(new_edge);
      end
      S_ADD_C: begin
        // chain the previous tail onto the new entry
        edge_req.wr_link = !link_null(add_tail);
        edge_req.addr    = add_tail[EIDX_W-1:0];
        edge_req.link    = LINK_W'(add_edge);
      end
      S_EDGE: begin
        list_req.addr = x_idx;
        stk_we        = take_x;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      edges_used <= '0;
      tick       <= '0;
      sp         <= '0;
      seen       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_ADD: begin
                if (add_drop) begin
                  status <= ST_DROPPED;
                  node   <= from_node;
                  stamp  <= '0;
                  last   <= 1'b1;
                end else begin
                  add_from <= from_node;
                  add_to   <= to_node;
                  state    <= S_ADD_B;
                end
              end
              OP_RUN: begin
                if (node_ok(from_node)) begin
                  seen     <= NODES'(1) << from_node[SIDX_W-1:0];
                  status   <= ST_ENTER;
                  node     <= from_node;
                  stamp    <= '0;
                  last     <= 1'b0;
                  tick     <= TICK_W'(1);
                  top_node <= from_node;
                  sp       <= SP_W'(1);
                  state    <= S_HEAD;
                end
              end
              OP_CLEAR: begin
                edges_used <= '0;
                status     <= ST_CLEARED;
                node       <= '0;
                stamp      <= '0;
                last       <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_B: begin
          add_tail   <= list_rd_tail;
          add_edge   <= new_edge;
          edges_used <= edges_used + CNT_W'(1);
          state      <= S_ADD_C;
        end
        S_ADD_C: begin
          status <= ST_STORED;
          node   <= add_from;
          stamp  <= '0;
          last   <= 1'b1;
          state  <= S_IDLE;
        end
        S_HEAD: begin
          top_cur <= list_rd_head;
          state   <= S_STEP;
        end
        S_STEP: begin
          if (link_null(top_cur)) begin
            status <= ST_LEAVE;
            node   <= top_node;
            stamp  <= tick;
            last   <= (sp == SP_W'(1));
            tick   <= tick + TICK_W'(1);
            sp     <= sp_m1;
            state  <= (sp == SP_W'(1)) ? S_IDLE : S_POP;
          end else begin
            state <= S_EDGE;
          end
        end
        S_POP: begin
          top_node <= stk_rdata.node;
          top_cur  <= stk_rdata.cur;
          state    <= S_STEP;
        end
        S_EDGE: begin
          if (take_x) begin
            seen[x_idx] <= 1'b1;
            status      <= ST_ENTER;
            node        <= edge_rd_target;
            stamp       <= tick;
            last        <= 1'b0;
            tick        <= tick + TICK_W'(1);
            top_node    <= edge_rd_target;
            sp          <= sp + SP_W'(1);
            state       <= S_HEAD;
          end else begin
            top_cur <= edge_rd_link;
            state   <= S_STEP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  det_edge_mem u_edge_mem (
    .clk       (clk),
    .req       (edge_req),
    .rd_target (edge_rd_target),
    .rd_link   (edge_rd_link)
  );

  det_list_mem u_list_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (list_req),
    .rd_head (list_rd_head),
    .rd_tail (list_rd_tail)
  );

  det_stack_mem u_stack_mem (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  `DET_ASSERT(a_mid_result_busy, clk, rst, (strobe && !last) |-> busy)
  `DET_ASSERT(a_enter_not_last, clk, rst, (strobe && status == ST_ENTER) |-> !last)
  `DET_ASSERT(a_last_frees, clk, rst, (strobe && last) |-> !busy)
  `DET_NEVER(a_sp_bound, clk, rst, sp > SP_W'(NODES))
  `DET_NEVER(a_edges_bound, clk, rst, edges_used > CNT_W'(EDGES))

endmodule
